// ===== src/ifrt_pkg.sv =====
// ----------------------------------------------------------------------------
// ifrt_pkg
// Types and constants shared by the fragment reassembly tracker modules.
// ----------------------------------------------------------------------------
package ifrt_pkg;

  localparam logic [16:0] MAX_BYTES = 17'd65535;

  typedef enum logic [2:0] {
    ST_REJECTED  = 3'd0,
    ST_NO_SLOT   = 3'd1,
    ST_FULL      = 3'd2,
    ST_OVERLAP   = 3'd3,
    ST_STORED    = 3'd4,
    ST_COMPLETE  = 3'd5,
    ST_TOO_LONG  = 3'd6
  } frag_status_t;

  typedef struct packed {
    logic [3:0]  device_id;
    logic [31:0] source_address;
    logic [31:0] destination_address;
    logic [15:0] identification;
    logic [7:0]  protocol_number;
    logic [12:0] offset_units;
    logic        more_fragments;
    logic [5:0]  header_bytes;
    logic [15:0] total_bytes;
    logic [31:0] now_tick;
  } frag_in_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [1:0]  slot_index;
    logic [15:0] assembled_payload;
    logic [5:0]  assembled_header;
  } frag_out_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_CHECK,
    S_MATCH,
    S_SCAN_RD,
    S_SCAN,
    S_STORE,
    S_WALK_INIT,
    S_WALK_RD,
    S_WALK,
    S_WALK_STEP,
    S_FINISH,
    S_OUT
  } ctrl_state_t;

  // controller to datapath
  typedef struct packed {
    logic load;       // capture input item
    logic expire;     // age out idle slots
    logic match;      // find or claim slot
    logic scan_rd;    // issue range read at scan index
    logic scan_adv;   // advance scan index
    logic store;      // record the range
    logic walk_init;  // pos = 0, restart walk
    logic walk_rd;    // issue range read at walk index
    logic walk_adv;   // advance walk search index
    logic walk_step;  // take hit, restart search
    logic finish;     // build result
    logic set_out;    // set a fixed-status result
    logic [2:0] out_status;
  } ctrl_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic bad;        // fragment rejected
    logic found;      // slot matched or claimed
    logic full;       // range list full
    logic scan_end;   // scan index reached count
    logic overlap;    // range read overlaps
    logic walk_test;  // header set, completion worth testing
    logic walk_end;   // search index reached count
    logic walk_hit;   // range read starts at pos
    logic pos_done;   // pos equals total
    logic pos_over;   // pos beyond total
    logic iter_end;   // walk iterations used up
    logic last_seen;
  } ctrl_stat_t;

endpackage

// ===== src/ipv4_fragment_reassembly_tracker.sv =====
// ----------------------------------------------------------------------------
// ipv4_fragment_reassembly_tracker
// Tracks IPv4 fragment ranges per reassembly slot and reports completion.
// ----------------------------------------------------------------------------
// Each fragment is checked, matched to a slot, scanned for overlap against
// the recorded ranges and stored; if the slot holds its header fragment, a
// completion walk probes ranges and follows the chain, then builds a result.
// One fragment at a time: a new one is taken only after the last result has
// been transferred. Scan and walk share the single range RAM read port.
// Reset: synchronous; clears all slots and sets timeout_ticks to 10000.
module ipv4_fragment_reassembly_tracker
  import ifrt_pkg::*;
#(
  parameter int NUM_SLOTS       = 4,
  parameter int RANGES_PER_SLOT = 32,
  parameter int DEVICE_BITS     = 4
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  frag_in_t    in_data,
  output logic        out_valid,
  input  logic        out_stall,
  output frag_out_t   out_data,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic        paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  ctrl_cmd_t   cmd;
  ctrl_stat_t  stat;
  logic [31:0] timeout_ticks;

  assign pready = 1'b1;
  assign prdata = (paddr == 1'b0) ? timeout_ticks : 32'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      timeout_ticks <= 32'd10000;
    end else if (psel && penable && pwrite && paddr == 1'b0) begin
      timeout_ticks <= pwdata;
    end
  end

  ifrt_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .stat      (stat),
    .cmd       (cmd)
  );

  ifrt_dp #(
    .NUM_SLOTS       (NUM_SLOTS),
    .RANGES_PER_SLOT (RANGES_PER_SLOT),
    .DEVICE_BITS     (DEVICE_BITS)
  ) u_dp (
    .clk           (clk),
    .rst           (rst),
    .in_data       (in_data),
    .timeout_ticks (timeout_ticks),
    .cmd           (cmd),
    .stat          (stat),
    .out_data      (out_data)
  );

endmodule

// ===== src/ifrt_ram.sv =====
// ----------------------------------------------------------------------------
// ifrt_ram
// Generic single-port write, single-port read RAM with registered read.
// ----------------------------------------------------------------------------
module ifrt_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 128
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== src/ifrt_ctrl.sv =====
// ----------------------------------------------------------------------------
// ifrt_ctrl
// Sequencer for one fragment: check, match, overlap scan, store, chain walk.
// ----------------------------------------------------------------------------
module ifrt_ctrl
  import ifrt_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  output logic       out_valid,
  input  logic       out_stall,
  input  ctrl_stat_t stat,
  output ctrl_cmd_t  cmd
);

  ctrl_state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_stall   = 1'b1;
    out_valid  = 1'b0;
    unique case (state)
      S_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = S_CHECK;
        end
      end
      S_CHECK: begin
        if (stat.bad) begin
          cmd.set_out    = 1'b1;
          cmd.out_status = ST_REJECTED;
          state_next     = S_OUT;
        end else begin
          cmd.expire = 1'b1;
          state_next = S_MATCH;
        end
      end
      S_MATCH: begin
        cmd.match = 1'b1;
        if (!stat.found) begin
          cmd.set_out    = 1'b1;
          cmd.out_status = ST_NO_SLOT;
          state_next     = S_OUT;
        end else begin
          state_next = S_SCAN_RD;
        end
      end
      S_SCAN_RD: begin
        if (stat.full) begin
          cmd.set_out    = 1'b1;
          cmd.out_status = ST_FULL;
          state_next     = S_OUT;
        end else if (stat.scan_end) begin
          state_next = S_STORE;
        end else begin
          cmd.scan_rd = 1'b1;
          state_next  = S_SCAN;
        end
      end
      S_SCAN: begin
        if (stat.overlap) begin
          cmd.set_out    = 1'b1;
          cmd.out_status = ST_OVERLAP;
          state_next     = S_OUT;
        end else begin
          cmd.scan_adv = 1'b1;
          state_next   = S_SCAN_RD;
        end
      end
      S_STORE: begin
        cmd.store  = 1'b1;
        state_next = S_WALK_INIT;
      end
      S_WALK_INIT: begin
        if (!stat.walk_test) begin
          cmd.set_out    = 1'b1;
          cmd.out_status = ST_STORED;
          state_next     = S_OUT;
        end else begin
          cmd.walk_init = 1'b1;
          state_next    = S_WALK_RD;
        end
      end
      S_WALK_RD: begin
        if (stat.walk_end) begin
          cmd.set_out    = 1'b1;
          cmd.out_status = ST_STORED;
          state_next     = S_OUT;
        end else begin
          cmd.walk_rd = 1'b1;
          state_next  = S_WALK;
        end
      end
      S_WALK: begin
        if (stat.walk_hit) begin
          cmd.walk_step = 1'b1;
          state_next    = S_WALK_STEP;
        end else begin
          cmd.walk_adv = 1'b1;
          state_next   = S_WALK_RD;
        end
      end
      S_WALK_STEP: begin
        if (stat.pos_done) begin
          if (stat.last_seen) begin
            state_next = S_FINISH;
          end else begin
            cmd.set_out    = 1'b1;
            cmd.out_status = ST_STORED;
            state_next     = S_OUT;
          end
        end else if (stat.pos_over || stat.iter_end) begin
          cmd.set_out    = 1'b1;
          cmd.out_status = ST_STORED;
          state_next     = S_OUT;
        end else begin
          state_next = S_WALK_RD;
        end
      end
      S_FINISH: begin
        cmd.finish = 1'b1;
        state_next = S_OUT;
      end
      S_OUT: begin
        out_valid = 1'b1;
        if (!out_stall) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

endmodule

// ===== src/ifrt_dp.sv =====
// ----------------------------------------------------------------------------
// ifrt_dp
// Slot table, range memories, scan and walk pointers, result register.
// ----------------------------------------------------------------------------
module ifrt_dp
  import ifrt_pkg::*;
#(
  parameter int NUM_SLOTS       = 4,
  parameter int RANGES_PER_SLOT = 32,
  parameter int DEVICE_BITS     = 4
) (
  input  logic        clk,
  input  logic        rst,
  input  frag_in_t    in_data,
  input  logic [31:0] timeout_ticks,
  input  ctrl_cmd_t   cmd,
  output ctrl_stat_t  stat,
  output frag_out_t   out_data
);

  localparam int SW     = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
  localparam int RW     = $clog2(RANGES_PER_SLOT);
  localparam int CW     = $clog2(RANGES_PER_SLOT + 1);
  localparam int RDEPTH = NUM_SLOTS * (2 ** RW);
  localparam int AW     = $clog2(RDEPTH);
  localparam int IW     = $clog2(RANGES_PER_SLOT + 2);
  // only the device bits that the descriptor carries take part in the match
  localparam int DB     = (DEVICE_BITS < 4) ? DEVICE_BITS : 4;

  frag_in_t item;
  logic [15:0] off;
  logic [16:0] endb;
  logic [16:0] plen;

  logic [NUM_SLOTS-1:0] slot_valid, slot_have_last;
  logic [5:0]            slot_header_len [NUM_SLOTS];
  logic [CW-1:0]         slot_range_count [NUM_SLOTS];
  logic [15:0]           slot_total [NUM_SLOTS];
  logic [15:0]           slot_key_ident [NUM_SLOTS];
  logic [31:0]           slot_key_src [NUM_SLOTS];
  logic [31:0]           slot_key_dst [NUM_SLOTS];
  logic [7:0]            slot_key_proto [NUM_SLOTS];
  logic [DB-1:0]         slot_key_dev [NUM_SLOTS];
  logic [31:0]           slot_last_tick [NUM_SLOTS];

  logic [SW-1:0] cur;
  logic [CW-1:0] idx;
  logic [IW-1:0] iter;
  logic [16:0]   pos;
  logic [31:0]   rd;
  logic [15:0]   rd_start, rd_end;

  logic [SW-1:0] hit_slot, free_slot;
  logic          hit_any, free_any;
  logic [AW-1:0] raddr, waddr;

  assign off  = {item.offset_units, 3'b000};
  assign plen = {1'b0, item.total_bytes} - {11'd0, item.header_bytes};
  assign endb = {1'b0, off} + plen;
  assign rd_start = rd[31:16];
  assign rd_end   = rd[15:0];

  // slot search over a handful of slots
  always_comb begin
    hit_slot  = '0;
    free_slot = '0;
    hit_any   = 1'b0;
    free_any  = 1'b0;
    for (int s = NUM_SLOTS - 1; s >= 0; s--) begin
      if (slot_valid[s] && slot_key_dev[s] == item.device_id[DB-1:0] &&
          slot_key_src[s] == item.source_address &&
          slot_key_dst[s] == item.destination_address &&
          slot_key_ident[s] == item.identification &&
          slot_key_proto[s] == item.protocol_number) begin
        hit_slot = SW'(s);
        hit_any  = 1'b1;
      end
      if (!slot_valid[s]) begin
        free_slot = SW'(s);
        free_any  = 1'b1;
      end
    end
  end

  always_comb begin
    if (NUM_SLOTS > 1) begin
      raddr = AW'({cur, idx[RW-1:0]});
      waddr = AW'({cur, slot_range_count[cur][RW-1:0]});
    end else begin
      raddr = AW'(idx[RW-1:0]);
      waddr = AW'(slot_range_count[cur][RW-1:0]);
    end
  end

  ifrt_ram #(.WIDTH(32), .DEPTH(RDEPTH)) u_ranges (
    .clk   (clk),
    .we    (cmd.store),
    .waddr (waddr),
    .wdata ({off, endb[15:0]}),
    .raddr (raddr),
    .rdata (rd)
  );

  always_comb begin
    stat.bad       = (item.total_bytes < {10'd0, item.header_bytes}) ||
                     (plen == 17'd0) || (endb > MAX_BYTES);
    stat.found     = hit_any || free_any;
    stat.full      = slot_range_count[cur] >= CW'(RANGES_PER_SLOT);
    stat.scan_end  = idx >= slot_range_count[cur];
    stat.overlap   = ({1'b0, off} < {1'b0, rd_end}) && (endb > {1'b0, rd_start});
    stat.walk_test = slot_header_len[cur] != 6'd0;
    stat.walk_end  = idx >= slot_range_count[cur];
    stat.walk_hit  = {1'b0, rd_start} == pos;
    stat.pos_done  = pos == {1'b0, slot_total[cur]};
    stat.pos_over  = pos > {1'b0, slot_total[cur]};
    stat.iter_end  = iter > IW'(RANGES_PER_SLOT);
    stat.last_seen = slot_have_last[cur];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      slot_valid     <= '0;
      slot_have_last <= '0;
      for (int s = 0; s < NUM_SLOTS; s++) begin
        slot_header_len[s]  <= '0;
        slot_range_count[s] <= '0;
        slot_total[s]       <= '0;
      end
    end else begin
      if (cmd.expire) begin
        for (int s = 0; s < NUM_SLOTS; s++) begin
          if (slot_valid[s] && (item.now_tick - slot_last_tick[s]) >= timeout_ticks) begin
            slot_valid[s] <= 1'b0;
          end
        end
      end
      if (cmd.match && !hit_any && free_any) begin
        slot_valid[free_slot]       <= 1'b1;
        slot_have_last[free_slot]   <= 1'b0;
        slot_header_len[free_slot]  <= '0;
        slot_range_count[free_slot] <= '0;
        slot_total[free_slot]       <= '0;
      end
      if (cmd.set_out && cmd.out_status == ST_OVERLAP) begin
        slot_valid[cur] <= 1'b0;
      end
      if (cmd.store) begin
        if (off == 16'd0) begin
          slot_header_len[cur] <= item.header_bytes;
        end
        slot_range_count[cur] <= slot_range_count[cur] + CW'(1);
        if (!item.more_fragments) begin
          slot_have_last[cur] <= 1'b1;
          slot_total[cur]     <= endb[15:0];
        end
      end
      if (cmd.finish) begin
        slot_valid[cur] <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      item <= in_data;
    end
    if (cmd.match) begin
      cur <= hit_any ? hit_slot : free_slot;
      idx <= '0;
      if (!hit_any && free_any) begin
        slot_key_dev[free_slot]   <= item.device_id[DB-1:0];
        slot_key_src[free_slot]   <= item.source_address;
        slot_key_dst[free_slot]   <= item.destination_address;
        slot_key_ident[free_slot] <= item.identification;
        slot_key_proto[free_slot] <= item.protocol_number;
      end
    end
    if (cmd.scan_adv || cmd.walk_adv) begin
      idx <= idx + CW'(1);
    end
    if (cmd.store) begin
      slot_last_tick[cur] <= item.now_tick;
    end
    if (cmd.walk_init) begin
      pos  <= '0;
      idx  <= '0;
      iter <= '0;
    end
    if (cmd.walk_step) begin
      pos  <= {1'b0, rd_end};
      idx  <= '0;
      iter <= iter + IW'(1);
    end
    if (cmd.set_out) begin
      out_data.status            <= cmd.out_status;
      out_data.slot_index        <= (cmd.out_status == ST_REJECTED ||
                                     cmd.out_status == ST_NO_SLOT) ? 2'd0 : 2'(cur);
      out_data.assembled_payload <= '0;
      out_data.assembled_header  <= '0;
    end
    if (cmd.finish) begin
      out_data.status <= ({1'b0, slot_total[cur]} + {11'd0, slot_header_len[cur]} > MAX_BYTES)
                         ? ST_TOO_LONG : ST_COMPLETE;
      out_data.slot_index        <= 2'(cur);
      out_data.assembled_payload <= slot_total[cur];
      out_data.assembled_header  <= slot_header_len[cur];
    end
  end

endmodule
